@@ hw/rtl/sfpd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfpd_pkg
// shared constants and types for the signed fixed-point divider
// ----------------------------------------------------------------------------
`default_nettype none

package sfpd_pkg;

   // default operand width
   localparam int DATA_WIDTH_DEFAULT = 16;

   // fraction-bit register
   localparam int FRAC_WIDTH = 4;
   localparam logic [FRAC_WIDTH-1:0] FRAC_RESET = 4'd8;

   // register port geometry
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int WORD_LSB = 2;

   // register word indexes
   localparam logic [CSR_ADDR_WIDTH-WORD_LSB-1:0] REG_FRAC_BITS = 1'b0;

   // per-item flags that ride along the pipeline
   typedef struct packed {
      logic negate;
      logic zero_div;
   } side_type;

endpackage

`default_nettype wire

@@ hw/rtl/sfpd_step.sv @@
// ----------------------------------------------------------------------------
// sfpd_step
// one registered compare-subtract step of the restoring divider
// ----------------------------------------------------------------------------
`default_nettype none

module sfpd_step #(
   parameter int DATA_WIDTH = sfpd_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 advance,
   input  wire                                 in_valid,
   input  wire  [DATA_WIDTH-1:0]               in_rem,
   input  wire  [DATA_WIDTH-1:0]               in_dv,
   input  wire  [DATA_WIDTH-1:0]               in_bits,
   input  wire  [$clog2(DATA_WIDTH+1)-1:0]     in_n,
   input  sfpd_pkg::side_type                  in_side,
   output logic                                out_valid,
   output logic [DATA_WIDTH-1:0]               out_rem,
   output logic [DATA_WIDTH-1:0]               out_dv,
   output logic [DATA_WIDTH-1:0]               out_bits,
   output logic [$clog2(DATA_WIDTH+1)-1:0]     out_n,
   output sfpd_pkg::side_type                  out_side
);

   localparam int NW = $clog2(DATA_WIDTH+1);

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dv_ff, dv_in;
   logic [DATA_WIDTH-1:0] bits_ff, bits_in;
   logic [NW-1:0]         n_ff;
   sfpd_pkg::side_type    side_ff;
   logic                  fits;

   // fits means the shifted divisor goes into the partial remainder
   always_comb begin
      fits    = (in_rem >= in_dv);
      rem_in  = fits ? (in_rem - in_dv) : in_rem;
      dv_in   = in_dv >> 1;
      // earliest step ends up in the top bit after all steps
      bits_in = {in_bits[DATA_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         rem_ff  <= rem_in;
         dv_ff   <= dv_in;
         bits_ff <= bits_in;
         n_ff    <= in_n;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_dv    = dv_ff;
   assign out_bits  = bits_ff;
   assign out_n     = n_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

@@ hw/rtl/signed_fixed_point_divide.sv @@
// ----------------------------------------------------------------------------
// signed_fixed_point_divide
// pipelined signed fixed-point divider, sign-magnitude restoring division
// ----------------------------------------------------------------------------
// The divider accepts one item per clock while req_stall is low and returns
// one result per item, in order. The pipeline is an input stage that takes
// magnitudes and the result sign, a stage that finds the divisor's bit length
// and normalizes it, one compare-subtract stage per quotient bit, a stage that
// moves the collected quotient bits to their fixed-point weight, and an output
// register that applies the sign. Each stage holds while it and every stage
// after it are full and the result is stalled, so empty slots close up and new
// items are taken while a finished result waits. A zero divisor gives
// quotient 0 with divide_by_zero set. The user must write frac_bits over the
// register port while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_fixed_point_divide #(
   parameter int DATA_WIDTH = sfpd_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // input channel
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [DATA_WIDTH-1:0]                 req_dividend,
   input  wire  [DATA_WIDTH-1:0]                 req_divisor,
   // result channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [DATA_WIDTH-1:0]                 rsp_quotient,
   output logic                                  rsp_divide_by_zero,
   // register port
   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire  [sfpd_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  wire  [sfpd_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [sfpd_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                  pready
);

   localparam int NW       = $clog2(DATA_WIDTH+1);
   localparam int FW       = sfpd_pkg::FRAC_WIDTH;
   localparam int FRAC_MAX = (1 << FW) - 1;
   // placement word: quotient bits parked above a window wide enough for any
   // combination of fraction bits and divisor length
   localparam int BW       = 2*DATA_WIDTH + FRAC_MAX + 1;
   localparam int AW       = $clog2(BW);
   // stage map
   localparam int NS       = DATA_WIDTH + 4;
   localparam int ST_PLACE = DATA_WIDTH + 2;
   localparam int ST_OUT   = DATA_WIDTH + 3;

   // ------------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------------
   logic [FW-1:0] frac_ff;
   logic          csr_write;
   logic          frac_sel;

   assign frac_sel  = (paddr[sfpd_pkg::CSR_ADDR_WIDTH-1:sfpd_pkg::WORD_LSB]
                       == sfpd_pkg::REG_FRAC_BITS);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff <= sfpd_pkg::FRAC_RESET;
      end else if (csr_write && frac_sel) begin
         frac_ff <= pwdata[FW-1:0];
      end
   end

   // only the low bits of the word hold anything
   always_comb begin
      prdata = '0;
      if (frac_sel) begin
         prdata[FW-1:0] = frac_ff;
      end
   end

   // ------------------------------------------------------------------------
   // flow control: a stage moves when some stage at or after it is empty or
   // the result is being taken
   // ------------------------------------------------------------------------
   logic [NS-1:0] stage_valid;
   logic [NS-1:0] adv;

   for (genvar g = 0; g < NS; g++) begin : g_adv
      assign adv[g] = !rsp_stall || !(&stage_valid[NS-1:g]);
   end

   assign req_stall = !adv[0];

   // ------------------------------------------------------------------------
   // stage 0: magnitudes and result sign
   // ------------------------------------------------------------------------
   logic                  s0_valid_ff;
   logic [DATA_WIDTH-1:0] s0_a_ff, s0_a_in;
   logic [DATA_WIDTH-1:0] s0_b_ff, s0_b_in;
   sfpd_pkg::side_type    s0_side_ff;
   logic                  a_neg, b_neg;

   always_comb begin
      a_neg   = req_dividend[DATA_WIDTH-1];
      b_neg   = req_divisor[DATA_WIDTH-1];
      // most negative value keeps its bit pattern, read as unsigned
      s0_a_in = a_neg ? (~req_dividend + DATA_WIDTH'(1)) : req_dividend;
      s0_b_in = b_neg ? (~req_divisor + DATA_WIDTH'(1)) : req_divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv[0]) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0] && req_valid) begin
         s0_a_ff             <= s0_a_in;
         s0_b_ff             <= s0_b_in;
         s0_side_ff.negate   <= a_neg ^ b_neg;
         s0_side_ff.zero_div <= (req_divisor == '0);
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: divisor bit length and normalization
   // ------------------------------------------------------------------------
   logic                  s1_valid_ff;
   logic [DATA_WIDTH-1:0] s1_rem_ff;
   logic [DATA_WIDTH-1:0] s1_dv_ff, s1_dv_in;
   logic [NW-1:0]         s1_n_ff, s1_n_in;
   sfpd_pkg::side_type    s1_side_ff;
   logic [DATA_WIDTH-1:0] top_bit;

   // one-hot of the leading one, then its position plus one
   always_comb begin
      s1_n_in = '0;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         top_bit[i] = s0_b_ff[i] && ((s0_b_ff >> (i + 1)) == '0);
         s1_n_in    = s1_n_in | ({NW{top_bit[i]}} & NW'(i + 1));
      end
      // top set bit lands in the word's top bit; zero divisor stays zero
      s1_dv_in = s0_b_ff << (NW'(DATA_WIDTH) - s1_n_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv[1]) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1] && s0_valid_ff) begin
         s1_rem_ff  <= s0_a_ff;
         s1_dv_ff   <= s1_dv_in;
         s1_n_ff    <= s1_n_in;
         s1_side_ff <= s0_side_ff;
      end
   end

   // ------------------------------------------------------------------------
   // compare-subtract stages, one per quotient bit
   // ------------------------------------------------------------------------
   logic [DATA_WIDTH:0]   valid_c;
   logic [DATA_WIDTH-1:0] rem_c  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] dv_c   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] bits_c [0:DATA_WIDTH];
   logic [NW-1:0]         n_c    [0:DATA_WIDTH];
   sfpd_pkg::side_type    side_c [0:DATA_WIDTH];

   assign valid_c[0] = s1_valid_ff;
   assign rem_c[0]   = s1_rem_ff;
   assign dv_c[0]    = s1_dv_ff;
   assign bits_c[0]  = '0;
   assign n_c[0]     = s1_n_ff;
   assign side_c[0]  = s1_side_ff;

   for (genvar j = 0; j < DATA_WIDTH; j++) begin : g_step
      sfpd_step #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (adv[j+2]),
         .in_valid  (valid_c[j]),
         .in_rem    (rem_c[j]),
         .in_dv     (dv_c[j]),
         .in_bits   (bits_c[j]),
         .in_n      (n_c[j]),
         .in_side   (side_c[j]),
         .out_valid (valid_c[j+1]),
         .out_rem   (rem_c[j+1]),
         .out_dv    (dv_c[j+1]),
         .out_bits  (bits_c[j+1]),
         .out_n     (n_c[j+1]),
         .out_side  (side_c[j+1])
      );
      assign stage_valid[j+2] = valid_c[j+1];
   end

   // ------------------------------------------------------------------------
   // placement: bit of step i belongs at frac_bits + width - n - i; bits
   // above the word wrap away, bits below bit 0 drop
   // ------------------------------------------------------------------------
   logic                  s2_valid_ff;
   logic [DATA_WIDTH-1:0] s2_p_ff;
   sfpd_pkg::side_type    s2_side_ff;
   logic [AW-1:0]         place_amt;
   logic [BW-1:0]         place_word;
   logic [BW-1:0]         place_shifted;

   always_comb begin
      place_amt     = AW'(DATA_WIDTH + FRAC_MAX) - AW'(frac_ff)
                      + AW'(n_c[DATA_WIDTH]);
      place_word    = {bits_c[DATA_WIDTH], {(BW - DATA_WIDTH){1'b0}}};
      place_shifted = place_word >> place_amt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv[ST_PLACE]) begin
         s2_valid_ff <= valid_c[DATA_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_PLACE] && valid_c[DATA_WIDTH]) begin
         s2_p_ff    <= place_shifted[DATA_WIDTH-1:0];
         s2_side_ff <= side_c[DATA_WIDTH];
      end
   end

   // ------------------------------------------------------------------------
   // output register: sign and zero-divisor override
   // ------------------------------------------------------------------------
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_quotient_ff, rsp_quotient_in;
   logic                  rsp_dbz_ff;

   always_comb begin
      if (s2_side_ff.zero_div) begin
         rsp_quotient_in = '0;
      end else if (s2_side_ff.negate) begin
         rsp_quotient_in = ~s2_p_ff + DATA_WIDTH'(1);
      end else begin
         rsp_quotient_in = s2_p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv[ST_OUT]) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT] && s2_valid_ff) begin
         rsp_quotient_ff <= rsp_quotient_in;
         rsp_dbz_ff      <= s2_side_ff.zero_div;
      end
   end

   assign stage_valid[0]        = s0_valid_ff;
   assign stage_valid[1]        = s1_valid_ff;
   assign stage_valid[ST_PLACE] = s2_valid_ff;
   assign stage_valid[ST_OUT]   = rsp_valid_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quotient       = rsp_quotient_ff;
   assign rsp_divide_by_zero = rsp_dbz_ff;

endmodule

`default_nettype wire

@@ hw/rtl/sfpd_checker.sv @@
// ----------------------------------------------------------------------------
// sfpd_checker
// port-level assertions for the signed fixed-point divider
// ----------------------------------------------------------------------------
`default_nettype none

module sfpd_checker #(
   parameter int DATA_WIDTH = sfpd_pkg::DATA_WIDTH_DEFAULT
) (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 psel,
   input wire                                 penable,
   input wire                                 pwrite,
   input wire [sfpd_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input wire [sfpd_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   input wire [sfpd_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   input wire                                 pready,
   input wire                                 rsp_valid,
   input wire                                 rsp_stall,
   input wire [DATA_WIDTH-1:0]                rsp_quotient,
   input wire                                 rsp_divide_by_zero
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quotient)
                                 && $stable(rsp_divide_by_zero))
      else $error("stalled result changed");

   // zero divisor always reports a zero quotient
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_quotient == '0)
      else $error("divide by zero with nonzero quotient");

   // pipeline is empty right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a written fraction count reads back on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready
      && (paddr[sfpd_pkg::CSR_ADDR_WIDTH-1:sfpd_pkg::WORD_LSB] == sfpd_pkg::REG_FRAC_BITS)
      |=> (paddr[sfpd_pkg::CSR_ADDR_WIDTH-1:sfpd_pkg::WORD_LSB] != sfpd_pkg::REG_FRAC_BITS)
          || (prdata[sfpd_pkg::FRAC_WIDTH-1:0] == $past(pwdata[sfpd_pkg::FRAC_WIDTH-1:0])))
      else $error("fraction count readback differs from written value");

   // register port never waits and the upper read bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      pready && (prdata[sfpd_pkg::CSR_DATA_WIDTH-1:sfpd_pkg::FRAC_WIDTH] == '0))
      else $error("register port not ready or upper read bits set");

endmodule

bind signed_fixed_point_divide sfpd_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_sfpd_checker (.*);

`default_nettype wire
